@@ sv/fdp_pkg.sv @@
`timescale 1ns / 1ps

package fdp_pkg;

  // Time arithmetic width and the wider of it and the 32-bit port width
  localparam int TIME_WIDTH = 32;
  localparam int TIME_EXT_W = (TIME_WIDTH > 32) ? TIME_WIDTH : 32;

  // Remainder accumulator sum: 8-bit accumulator plus 8x4 product
  localparam int SUM_W     = 12;
  localparam int DIV_STEPS = SUM_W;
  localparam int IVL_W     = 20;

  // Register reset values
  localparam logic [15:0] BASE_RESET = 16'd16666;
  localparam logic [7:0]  FRAC_RESET = 8'd40;
  localparam logic [7:0]  RATE_RESET = 8'd60;

  localparam logic [30:0] WAIT_MAX = 31'h7FFF_FFFF;

  // Configuration register indexes
  localparam logic [7:0] CFG_BASE = 8'd0;
  localparam logic [7:0] CFG_FRAC = 8'd1;
  localparam logic [7:0] CFG_RATE = 8'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PROD,
    ST_SUM,
    ST_DIV,
    ST_IVL,
    ST_DIFF,
    ST_ADV,
    ST_DONE
  } state_t;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  typedef struct packed {
    alu_op_t               op;
    logic [TIME_WIDTH-1:0] a;
    logic [TIME_WIDTH-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic                  carry;
    logic [TIME_WIDTH-1:0] sum;
  } alu_rsp_t;

endpackage

@@ sv/fdp_alu.sv @@
`timescale 1ns / 1ps

module fdp_alu (
  input  fdp_pkg::alu_req_t req,
  output fdp_pkg::alu_rsp_t rsp
);
  import fdp_pkg::*;

  logic [TIME_WIDTH-1:0] b_in;
  logic [TIME_WIDTH:0]   total;

  // Add, or subtract by two's complement; carry out high means a >= b on subtract
  always_comb begin
    b_in  = (req.op == ALU_SUB) ? ~req.b : req.b;
    total = {1'b0, req.a} + {1'b0, b_in} + {{TIME_WIDTH{1'b0}}, (req.op == ALU_SUB)};
  end

  assign rsp.carry = total[TIME_WIDTH];
  assign rsp.sum   = total[TIME_WIDTH-1:0];

endmodule

@@ sv/frame_deadline_pacer.sv @@
`timescale 1ns / 1ps
// One frame event at a time: in_stall holds off the next input until the result is loaded
// into the output register. The 12 steps of the restoring divide by the refresh rate on the
// single shared adder take most of that time, and a stalled output that still holds a result
// keeps the new result waiting in ST_DONE, and the input stalled, until the output is free.
// Reset: registers return to 16666 / 40 / 60, deadline and accumulator clear,
// and the timeline is marked not started.
module frame_deadline_pacer (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] now_usec,
  input  logic [3:0]  rate_divisor,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [30:0] wait_usec,
  output logic        deadline_missed,
  output logic [31:0] next_deadline_usec
);
  import fdp_pkg::*;

  state_t state, state_next;

  logic [15:0] base_interval_usec;
  logic [7:0]  fraction_per_interval;
  logic [7:0]  refresh_rate_hz;

  logic [TIME_WIDTH-1:0] deadline_usec;
  logic [7:0]            fraction_accumulator;
  logic                  timeline_started;

  logic [TIME_WIDTH-1:0] now;
  logic [3:0]            divisor;
  logic [IVL_W-1:0]      base_prod;
  logic [SUM_W-1:0]      frac_prod;
  logic [SUM_W-1:0]      sum_sh;
  logic [SUM_W-1:0]      quot;
  logic [7:0]            rem;
  logic [3:0]            div_cnt;
  logic [TIME_WIDTH-1:0] interval;
  logic [30:0]           wait_r;
  logic                  missed_r;

  logic [TIME_EXT_W-1:0] now_ext;
  logic [TIME_EXT_W-1:0] diff_ext;
  logic [TIME_EXT_W-1:0] dl_ext;
  logic [7:0]            rate_eff;
  logic [8:0]            trial;
  logic                  div_last;
  logic                  in_xfer;

  alu_req_t alu_req;
  alu_rsp_t alu_rsp;

  fdp_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != ST_IDLE);
  assign in_xfer   = in_valid && !in_stall;

  assign now_ext  = TIME_EXT_W'(now_usec);
  assign diff_ext = TIME_EXT_W'(alu_rsp.sum);
  assign dl_ext   = TIME_EXT_W'(deadline_usec);
  assign rate_eff = (refresh_rate_hz == 8'd0) ? 8'd1 : refresh_rate_hz;
  assign trial    = {rem, sum_sh[SUM_W-1]};
  assign div_last = (div_cnt == 4'(DIV_STEPS - 1));

  // Sequence the shared adder and pick the next state
  always_comb begin
    state_next  = state;
    alu_req.op  = ALU_ADD;
    alu_req.a   = '0;
    alu_req.b   = '0;
    case (state)
      ST_IDLE: begin
        if (in_xfer) state_next = ST_PROD;
      end
      ST_PROD: begin
        state_next = ST_SUM;
      end
      ST_SUM: begin
        alu_req.a  = TIME_WIDTH'(fraction_accumulator);
        alu_req.b  = TIME_WIDTH'(frac_prod);
        state_next = ST_DIV;
      end
      ST_DIV: begin
        alu_req.op = ALU_SUB;
        alu_req.a  = TIME_WIDTH'(trial);
        alu_req.b  = TIME_WIDTH'(rate_eff);
        if (div_last) state_next = ST_IVL;
      end
      ST_IVL: begin
        alu_req.a  = TIME_WIDTH'(base_prod);
        alu_req.b  = TIME_WIDTH'(quot);
        state_next = ST_DIFF;
      end
      ST_DIFF: begin
        alu_req.op = ALU_SUB;
        alu_req.a  = deadline_usec;
        alu_req.b  = now;
        state_next = ST_ADV;
      end
      ST_ADV: begin
        alu_req.a  = deadline_usec;
        alu_req.b  = interval;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid || !out_stall) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      base_interval_usec    <= BASE_RESET;
      fraction_per_interval <= FRAC_RESET;
      refresh_rate_hz       <= RATE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_BASE: base_interval_usec    <= cfg_data;
        CFG_FRAC: fraction_per_interval <= cfg_data[7:0];
        CFG_RATE: refresh_rate_hz       <= cfg_data[7:0];
        default:  ;
      endcase
    end
  end

  // Pacing state
  always_ff @(posedge clk) begin
    if (rst) begin
      deadline_usec        <= '0;
      fraction_accumulator <= '0;
      timeline_started     <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_xfer && !timeline_started) begin
            deadline_usec    <= now_ext[TIME_WIDTH-1:0];
            timeline_started <= 1'b1;
          end
        end
        ST_DIV: begin
          if (div_last) fraction_accumulator <= alu_rsp.carry ? alu_rsp.sum[7:0] : trial[7:0];
        end
        ST_DIFF: begin
          if (alu_rsp.sum[TIME_WIDTH-1]) deadline_usec <= now;
        end
        ST_ADV: begin
          deadline_usec <= alu_rsp.sum;
        end
        default: ;
      endcase
    end
  end

  // Working registers of the current event
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_xfer) begin
          now     <= now_ext[TIME_WIDTH-1:0];
          divisor <= (rate_divisor == 4'd0) ? 4'd1 : rate_divisor;
        end
      end
      ST_PROD: begin
        base_prod <= IVL_W'(base_interval_usec) * IVL_W'(divisor);
        frac_prod <= SUM_W'(fraction_per_interval) * SUM_W'(divisor);
      end
      ST_SUM: begin
        sum_sh  <= alu_rsp.sum[SUM_W-1:0];
        rem     <= '0;
        quot    <= '0;
        div_cnt <= '0;
      end
      ST_DIV: begin
        // One quotient bit a step: keep the difference when the trial fits
        rem     <= alu_rsp.carry ? alu_rsp.sum[7:0] : trial[7:0];
        quot    <= {quot[SUM_W-2:0], alu_rsp.carry};
        sum_sh  <= {sum_sh[SUM_W-2:0], 1'b0};
        div_cnt <= div_cnt + 4'd1;
      end
      ST_IVL: begin
        interval <= alu_rsp.sum;
      end
      ST_DIFF: begin
        missed_r <= alu_rsp.sum[TIME_WIDTH-1];
        if (alu_rsp.sum[TIME_WIDTH-1] || (alu_rsp.sum == '0)) wait_r <= '0;
        else if (|diff_ext[TIME_EXT_W-1:31])                 wait_r <= WAIT_MAX;
        else                                                 wait_r <= diff_ext[30:0];
      end
      default: ;
    endcase
  end

  // Output register: load when free, drop valid on transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_DONE && (!out_valid || !out_stall)) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && (!out_valid || !out_stall)) begin
      wait_usec          <= wait_r;
      deadline_missed    <= missed_r;
      next_deadline_usec <= dl_ext[31:0];
    end
  end

endmodule
